// File: src/acc_cpu_pkg.sv
// package for the accumulator cpu: payload structs, sequencer codes, opcodes
// no dependencies
package acc_cpu_pkg;

  typedef struct packed {
    logic signed [31:0] response_word;
    logic               start_kick;
    logic [6:0]         random_value;
  } in_item_t;

  typedef struct packed {
    logic               request_write;
    logic signed [31:0] request_address;
    logic signed [31:0] request_data;
    logic               request_kernel;
    logic               port_valid;
    logic               port_is_char;
    logic signed [31:0] port_value;
    logic               halted;
  } out_item_t;

  localparam logic [3:0] S_FETCH = 4'd0;
  localparam logic [3:0] S_OPND  = 4'd1;
  localparam logic [3:0] S_DATA  = 4'd2;
  localparam logic [3:0] S_IND   = 4'd3;
  localparam logic [3:0] S_WACK  = 4'd4;
  localparam logic [3:0] S_PCLD  = 4'd5;
  localparam logic [3:0] S_CALLW = 4'd6;
  localparam logic [3:0] S_IRET1 = 4'd7;
  localparam logic [3:0] S_IRET2 = 4'd8;
  localparam logic [3:0] S_SYS1  = 4'd9;
  localparam logic [3:0] S_SYS2  = 4'd10;
  localparam logic [3:0] S_TIM1  = 4'd11;
  localparam logic [3:0] S_TIM2  = 4'd12;

  localparam logic [2:0] CFG_USTACK = 3'd0;
  localparam logic [2:0] CFG_SSTACK = 3'd1;
  localparam logic [2:0] CFG_SYSVEC = 3'd2;
  localparam logic [2:0] CFG_TIMVEC = 3'd3;
  localparam logic [2:0] CFG_PERIOD = 3'd4;

  // opcodes
  localparam int OP_LDV    = 1;
  localparam int OP_LDA    = 2;
  localparam int OP_LDI    = 3;
  localparam int OP_LDAX   = 4;
  localparam int OP_LDAY   = 5;
  localparam int OP_LDSPX  = 6;
  localparam int OP_STA    = 7;
  localparam int OP_GET    = 8;
  localparam int OP_PUT    = 9;
  localparam int OP_ADDX   = 10;
  localparam int OP_ADDY   = 11;
  localparam int OP_SUBX   = 12;
  localparam int OP_SUBY   = 13;
  localparam int OP_TOX    = 14;
  localparam int OP_FROMX  = 15;
  localparam int OP_TOY    = 16;
  localparam int OP_FROMY  = 17;
  localparam int OP_TOSP   = 18;
  localparam int OP_FROMSP = 19;
  localparam int OP_JMP    = 20;
  localparam int OP_JZ     = 21;
  localparam int OP_JNZ    = 22;
  localparam int OP_CALL   = 23;
  localparam int OP_RET    = 24;
  localparam int OP_INCX   = 25;
  localparam int OP_DECX   = 26;
  localparam int OP_PUSH   = 27;
  localparam int OP_POP    = 28;
  localparam int OP_END    = 50;
  localparam int OP_SYSC   = 29;
  localparam int OP_IRET   = 30;
  localparam int PORT_INT  = 1;
  localparam int PORT_CHR  = 2;

endpackage

// File: src/accumulator_cpu_with_timer_interrupt_top.sv
// accumulator cpu core with timer interrupt: one sequencer step per item; the
// result is registered in the cycle after acceptance, 1 item per cycle absent
// an output stall; the step is the register update plus next-address adders
// in one pass. the result register is a single stage; the input is stalled
// only while a result waits and the output side stalls. synchronous reset
// (active-high) restores architectural state and registers to reset values.
// depends on acc_cpu_pkg
module accumulator_cpu_with_timer_interrupt_top #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  acc_cpu_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output acc_cpu_pkg::out_item_t out_data,
  input  logic                   cfg_write,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data
);

  localparam int W = WORD_BITS;

  // sequencer steps, one per memory transaction
  typedef enum logic [3:0] {
    S_FETCH = 4'd0, S_OPND = 4'd1, S_DATA = 4'd2, S_IND = 4'd3, S_WACK = 4'd4,
    S_PCLD = 4'd5, S_CALLW = 4'd6, S_IRET1 = 4'd7, S_IRET2 = 4'd8,
    S_SYS1 = 4'd9, S_SYS2 = 4'd10, S_TIM1 = 4'd11, S_TIM2 = 4'd12
  } step_t;

  // config registers
  logic [15:0] ustack, sstack, sysvec, timvec, period;
  // architectural state
  logic [W-1:0] ac, ix, iy, sp, pc, ir, usave;
  logic [15:0]  phase;
  logic [31:0]  deferred;
  step_t        step;
  logic         kmode, stopped;

  logic [W-1:0] ac_next, ix_next, iy_next, sp_next, pc_next, ir_next, usave_next;
  logic [15:0]  phase_next;
  logic [31:0]  deferred_next;
  step_t        step_next;
  logic         kmode_next, stopped_next;
  acc_cpu_pkg::out_item_t res;

  logic         accept;
  logic [W-1:0] r;
  logic         rw;
  logic [W-1:0] raddr, rdata;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // sign-extend or truncate the response to the word width
  always_comb begin
    r = W'($signed(in_data.response_word));
  end

  // one sequencer step
  always_comb begin
    logic fin, take, fire, ib, pushw;
    logic [W-1:0] pdata;
    logic [15:0]  ph;
    ac_next = ac; ix_next = ix; iy_next = iy; sp_next = sp; pc_next = pc;
    ir_next = ir; usave_next = usave; phase_next = phase;
    deferred_next = deferred; step_next = step; kmode_next = kmode;
    stopped_next = stopped;
    res = '0;
    rw = 1'b0; raddr = '0; rdata = '0;
    fin = 1'b0; ib = 1'b0; pushw = 1'b0; pdata = '0;
    take = 1'b0; fire = 1'b0; ph = '0;
    if (in_data.start_kick) begin
      stopped_next = 1'b0;
      pc_next = '0;
      step_next = S_FETCH;
    end else if (!stopped) begin
      case (step)
        S_OPND: begin
          case (ir)
            W'(acc_cpu_pkg::OP_LDA): begin raddr = r; step_next = S_DATA; end
            W'(acc_cpu_pkg::OP_LDI): begin raddr = r; step_next = S_IND; end
            W'(acc_cpu_pkg::OP_LDAX): begin raddr = r + ix; step_next = S_DATA; end
            W'(acc_cpu_pkg::OP_LDAY): begin raddr = r + iy; step_next = S_DATA; end
            W'(acc_cpu_pkg::OP_STA): begin
              rw = 1'b1; raddr = r; rdata = ac; step_next = S_WACK;
            end
            W'(acc_cpu_pkg::OP_PUT): begin
              if (r == W'(acc_cpu_pkg::PORT_INT) || r == W'(acc_cpu_pkg::PORT_CHR)) begin
                res.port_valid   = 1'b1;
                res.port_is_char = (r == W'(acc_cpu_pkg::PORT_CHR));
                res.port_value   = 32'($signed(ac));
              end
              fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
        S_IND: begin raddr = r; step_next = S_DATA; end
        S_DATA: begin ac_next = r; fin = 1'b1; end
        S_WACK: fin = 1'b1;
        S_PCLD: begin pc_next = r; fin = 1'b1; end
        S_CALLW: begin
          raddr = pc; pc_next = pc + 1'b1; step_next = S_PCLD;
        end
        S_IRET1: begin
          pc_next = r; raddr = sp; sp_next = sp + 1'b1;
          step_next = S_IRET2;
        end
        S_IRET2: begin
          sp_next = r; kmode_next = 1'b0; fin = 1'b1;
        end
        S_SYS1: begin
          pushw = 1'b1; pdata = pc; step_next = S_SYS2;
        end
        S_SYS2: begin pc_next = W'(sysvec); fin = 1'b1; end
        S_TIM1: begin
          pushw = 1'b1; pdata = pc; step_next = S_TIM2;
        end
        S_TIM2: begin
          pc_next = W'(timvec); raddr = W'(timvec); step_next = S_FETCH;
        end
        default: begin
          // fetched instruction word, then execute
          ir_next = r;
          pc_next = pc + 1'b1;
          case (r)
            W'(acc_cpu_pkg::OP_LDV): begin
              raddr = pc_next; pc_next = pc + W'(2); step_next = S_DATA;
            end
            W'(acc_cpu_pkg::OP_LDA), W'(acc_cpu_pkg::OP_LDI), W'(acc_cpu_pkg::OP_LDAX),
            W'(acc_cpu_pkg::OP_LDAY), W'(acc_cpu_pkg::OP_STA), W'(acc_cpu_pkg::OP_PUT): begin
              raddr = pc_next; pc_next = pc + W'(2); step_next = S_OPND;
            end
            W'(acc_cpu_pkg::OP_LDSPX): begin raddr = sp + ix; step_next = S_DATA; end
            W'(acc_cpu_pkg::OP_GET): begin
              ac_next = W'(in_data.random_value); fin = 1'b1;
            end
            W'(acc_cpu_pkg::OP_ADDX): begin ac_next = ac + ix; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_ADDY): begin ac_next = ac + iy; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_SUBX): begin ac_next = ac - ix; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_SUBY): begin ac_next = ac - iy; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_TOX): begin ix_next = ac; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_FROMX): begin ac_next = ix; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_TOY): begin iy_next = ac; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_FROMY): begin ac_next = iy; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_TOSP): begin sp_next = ac; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_FROMSP): begin ac_next = sp; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_JMP): begin
              raddr = pc_next; pc_next = pc + W'(2); step_next = S_PCLD;
            end
            W'(acc_cpu_pkg::OP_JZ), W'(acc_cpu_pkg::OP_JNZ): begin
              if ((ac == '0) == (r == W'(acc_cpu_pkg::OP_JZ))) begin
                raddr = pc_next; pc_next = pc + W'(2); step_next = S_PCLD;
              end else begin
                pc_next = pc + W'(2); fin = 1'b1;
              end
            end
            W'(acc_cpu_pkg::OP_CALL): begin
              pushw = 1'b1; pdata = pc + W'(2); step_next = S_CALLW;
            end
            W'(acc_cpu_pkg::OP_RET): begin
              raddr = sp; sp_next = sp + 1'b1; step_next = S_PCLD;
            end
            W'(acc_cpu_pkg::OP_INCX): begin ix_next = ix + 1'b1; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_DECX): begin ix_next = ix - 1'b1; fin = 1'b1; end
            W'(acc_cpu_pkg::OP_PUSH): begin
              pushw = 1'b1; pdata = ac; step_next = S_WACK;
            end
            W'(acc_cpu_pkg::OP_POP): begin
              raddr = sp; sp_next = sp + 1'b1; step_next = S_DATA;
            end
            W'(acc_cpu_pkg::OP_SYSC): begin ib = 1'b1; step_next = S_SYS1; end
            W'(acc_cpu_pkg::OP_IRET): begin
              raddr = sp; sp_next = sp + 1'b1; step_next = S_IRET1;
            end
            W'(acc_cpu_pkg::OP_END): stopped_next = 1'b1;
            default: fin = 1'b1;
          endcase
        end
      endcase

      // end of instruction: timer bookkeeping
      if (fin) begin
        raddr = pc_next;
        step_next = S_FETCH;
        if (period == '0) begin
          phase_next = '0;
        end else begin
          ph = phase + 1'b1;
          if (ph >= period) begin ph = '0; fire = 1'b1; end
          phase_next = ph;
          if (!kmode_next && deferred != '0) begin
            take = 1'b1; deferred_next = deferred - 1'b1;
          end
          if (fire) begin
            if (!kmode_next && !take) take = 1'b1;
            else if (deferred_next != 32'hFFFF_FFFF) deferred_next = deferred_next + 1'b1;
          end
          if (take) begin ib = 1'b1; step_next = S_TIM1; end
        end
      end

      // interrupt entry: swap to system stack and push user sp
      if (ib) begin
        kmode_next = 1'b1;
        usave_next = sp_next;
        pdata = sp_next;
        sp_next = W'(sstack);
        pushw = 1'b1;
      end
      if (pushw) begin
        sp_next = sp_next - 1'b1;
        rw = 1'b1; raddr = sp_next; rdata = pdata;
      end
    end
    if (!stopped_next) begin
      res.request_write   = rw;
      res.request_address = 32'($signed(raddr));
      res.request_data    = 32'($signed(rdata));
      res.request_kernel  = kmode_next;
    end else begin
      res = '0;
      res.halted = 1'b1;
    end
  end

  // state, config and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ustack <= 16'd1000; sstack <= 16'd2000; sysvec <= 16'd1500;
      timvec <= 16'd1000; period <= '0;
      ac <= '0; ix <= '0; iy <= '0; sp <= W'(1000); pc <= '0; ir <= '0;
      usave <= '0; phase <= '0; deferred <= '0; step <= S_FETCH;
      kmode <= 1'b0; stopped <= 1'b0; out_valid <= 1'b0; out_data <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        ac <= ac_next; ix <= ix_next; iy <= iy_next; sp <= sp_next;
        pc <= pc_next; ir <= ir_next; usave <= usave_next; phase <= phase_next;
        deferred <= deferred_next; step <= step_next; kmode <= kmode_next;
        stopped <= stopped_next;
        out_data <= res; out_valid <= 1'b1;
      end
      if (cfg_write) begin
        case (cfg_index)
          acc_cpu_pkg::CFG_USTACK: begin ustack <= cfg_data; sp <= W'(cfg_data); end
          acc_cpu_pkg::CFG_SSTACK: sstack <= cfg_data;
          acc_cpu_pkg::CFG_SYSVEC: sysvec <= cfg_data;
          acc_cpu_pkg::CFG_TIMVEC: timvec <= cfg_data;
          acc_cpu_pkg::CFG_PERIOD: period <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // user stack top is kept for completeness of the register map
  logic unused_ok;
  assign unused_ok = ^ustack;

endmodule
